// ----- src/dq_pkg.sv -----
package dq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = 5;
	localparam int POS_W      = 5;
	localparam int CMD_W      = 3;
	localparam int STAT_W     = 2;

	localparam int S_FIELDS_W = CMD_W + POS_W + DATA_WIDTH;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = DATA_WIDTH + CNT_W + STAT_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_BACK   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_READ       = 3'd4,
		CMD_WRITE      = 3'd5,
		CMD_INSERT     = 3'd6,
		CMD_ERASE      = 3'd7
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RD_WAIT,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] read_value;
		logic [CNT_W-1:0]      count;
		status_t               status;
	} result_t;

	// ring slot of a logical index counted from the head
	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
			input logic [CNT_W-1:0] ofs);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + {1'b0, ofs};
		if (sum >= (CNT_W+1)'(DEPTH)) begin
			sum = sum - (CNT_W+1)'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

// ----- src/dq_ram.sv -----
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/dq_ctrl.sv -----
module dq_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  dq_pkg::cmd_t                 in_cmd,
	input  logic [dq_pkg::POS_W-1:0]     in_pos,
	input  logic [dq_pkg::DATA_WIDTH-1:0] in_val,
	output logic                         res_valid,
	input  logic                         res_ready,
	output dq_pkg::result_t              res,
	output logic                         ram_we,
	output logic [dq_pkg::PTR_W-1:0]     ram_waddr,
	output logic [dq_pkg::DATA_WIDTH-1:0] ram_wdata,
	output logic [dq_pkg::PTR_W-1:0]     ram_raddr,
	input  logic [dq_pkg::DATA_WIDTH-1:0] ram_rdata
);
	import dq_pkg::*;

	state_t                state_q, state_d;
	cmd_t                  cmd_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [PTR_W-1:0]      head_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      idx_q;
	logic [DATA_WIDTH-1:0] rd_q;
	status_t               status_q;

	status_t               st_exec;
	logic                  full, empty;
	logic [PTR_W-1:0]      head_dec, head_inc;
	logic                  ins_more, ers_more;

	assign full     = count_q >= CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign head_dec = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - 1'b1;
	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign ins_more = idx_q > CNT_W'(pos_q);
	assign ers_more = ({1'b0, idx_q} + 1'b1) < {1'b0, count_q};

	// checks in this order: full before index for insert, empty before index for erase
	always_comb begin
		st_exec = ST_OK;
		case (cmd_q)
			CMD_PUSH_BACK, CMD_PUSH_FRONT: if (full) st_exec = ST_FULL;
			CMD_POP_BACK, CMD_POP_FRONT:   if (empty) st_exec = ST_EMPTY;
			CMD_READ, CMD_WRITE:           if (CNT_W'(pos_q) >= count_q) st_exec = ST_RANGE;
			CMD_INSERT: begin
				if (full) st_exec = ST_FULL;
				else if (CNT_W'(pos_q) > count_q) st_exec = ST_RANGE;
			end
			CMD_ERASE: begin
				if (empty) st_exec = ST_EMPTY;
				else if (CNT_W'(pos_q) >= count_q) st_exec = ST_RANGE;
			end
			default: st_exec = ST_OK;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = state_q == S_IDLE;
		res_valid = state_q == S_FINISH;
		ram_we    = 1'b0;
		ram_waddr = slot_of(head_q, idx_q);
		ram_wdata = val_q;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_FINISH;
				if (st_exec == ST_OK) begin
					case (cmd_q)
						CMD_PUSH_BACK: begin
							ram_we    = 1'b1;
							ram_waddr = slot_of(head_q, count_q);
						end
						CMD_PUSH_FRONT: begin
							ram_we    = 1'b1;
							ram_waddr = head_dec;
						end
						CMD_POP_BACK: begin
							ram_raddr = slot_of(head_q, count_q - 1'b1);
							state_d   = S_RD_WAIT;
						end
						CMD_POP_FRONT: begin
							ram_raddr = head_q;
							state_d   = S_RD_WAIT;
						end
						CMD_READ, CMD_ERASE: begin
							ram_raddr = slot_of(head_q, CNT_W'(pos_q));
							state_d   = S_RD_WAIT;
						end
						CMD_WRITE: begin
							ram_we    = 1'b1;
							ram_waddr = slot_of(head_q, CNT_W'(pos_q));
						end
						CMD_INSERT: state_d = S_SHIFT_RD;
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_RD_WAIT: begin
				state_d = (cmd_q == CMD_ERASE) ? S_SHIFT_RD : S_FINISH;
			end
			S_SHIFT_RD: begin
				if (cmd_q == CMD_INSERT) begin
					if (ins_more) begin
						ram_raddr = slot_of(head_q, idx_q - 1'b1);
						state_d   = S_SHIFT_WR;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = slot_of(head_q, CNT_W'(pos_q));
						state_d   = S_FINISH;
					end
				end else begin
					if (ers_more) begin
						ram_raddr = slot_of(head_q, idx_q + 1'b1);
						state_d   = S_SHIFT_WR;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SHIFT_WR: begin
				// move the fetched element one place over
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				state_d   = S_SHIFT_RD;
			end
			S_FINISH: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_EXEC: begin
					if (st_exec == ST_OK) begin
						case (cmd_q)
							CMD_PUSH_BACK: count_q <= count_q + 1'b1;
							CMD_PUSH_FRONT: begin
								head_q  <= head_dec;
								count_q <= count_q + 1'b1;
							end
							CMD_POP_BACK: count_q <= count_q - 1'b1;
							CMD_POP_FRONT: begin
								head_q  <= head_inc;
								count_q <= count_q - 1'b1;
							end
							default: count_q <= count_q;
						endcase
					end
				end
				S_SHIFT_RD: begin
					if (cmd_q == CMD_INSERT && !ins_more) count_q <= count_q + 1'b1;
					if (cmd_q == CMD_ERASE && !ers_more) count_q <= count_q - 1'b1;
				end
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= in_cmd;
				pos_q <= in_pos;
				val_q <= in_val;
			end
			S_EXEC: begin
				status_q <= st_exec;
				rd_q     <= '0;
				idx_q    <= count_q;
			end
			S_RD_WAIT: begin
				rd_q  <= ram_rdata;
				idx_q <= CNT_W'(pos_q);
			end
			S_SHIFT_WR: begin
				idx_q <= (cmd_q == CMD_INSERT) ? idx_q - 1'b1 : idx_q + 1'b1;
			end
			default: idx_q <= idx_q;
		endcase
	end

	assign res.read_value = rd_q;
	assign res.count      = count_q;
	assign res.status     = status_q;

endmodule

// ----- src/double_ended_queue.sv -----
// push, write and any refused command pass through execute and finish, one item at a time;
// pop and read add a read-wait state, insert a shift loop and then its write, erase a read
// wait and then a shift loop; the loop does one ring store read and one write per moved element
// the result sits in an output register; the next item is taken while it waits
// arst_n clears head and count and leaves the store contents undefined
module double_ended_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// command[2:0], position[7:3], value[39:8]
	input  logic [dq_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// read_value[31:0], count[36:32], status[38:37], zero pad
	output logic [dq_pkg::M_TDATA_W-1:0]  m_tdata
);
	import dq_pkg::*;

	logic                  res_valid, res_ready;
	result_t               res;
	logic                  ram_we;
	logic [PTR_W-1:0]      ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
	logic                  m_tvalid_q;
	result_t               m_res_q;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (cmd_t'(s_tdata[CMD_W-1:0])),
		.in_pos    (s_tdata[CMD_W +: POS_W]),
		.in_val    (s_tdata[CMD_W+POS_W +: DATA_WIDTH]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	dq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register, refilled in the cycle its transfer completes
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_TDATA_W - M_FIELDS_W)'(0), m_res_q.status, m_res_q.count,
		m_res_q.read_value};

endmodule
